// ===== src/weighted_quantum_round_robin_macros.svh =====
// Assertion macros for the weighted quantum round-robin scheduler.
// Included by the modules that check their own control logic; needs no package.
`ifndef WEIGHTED_QUANTUM_ROUND_ROBIN_MACROS_SVH
`define WEIGHTED_QUANTUM_ROUND_ROBIN_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define WQRR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wqrr assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define WQRR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wqrr assertion failed");

`else

`define WQRR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define WQRR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/wqrr_pkg.sv =====
// Shared types and constants of the weighted quantum round-robin scheduler.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package wqrr_pkg;

    localparam int SLOT_W     = 3;
    localparam int BURST_W    = 8;
    localparam int PRIO_W     = 3;
    localparam int SLICE_W    = 9;
    localparam int TURN_W     = 9;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 32;

    // Item kinds carried on the input tuser bit.
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // Quantum = floor(median * (10 + p) / 10), computed as
    // (median * ceil((10 + p) * 2^16 / 10)) >> 16. The rounding error stays
    // below 0.005 for an 8-bit median, far under the 0.1 step of the exact value.
    localparam int COEF_SHIFT = 16;
    localparam int COEF_W     = 17;
    typedef logic [COEF_W-1:0] t_coef;
    localparam t_coef SLICE_COEF [8] = '{
        17'd65536, 17'd72090, 17'd78644, 17'd85197,
        17'd91751, 17'd98304, 17'd104858, 17'd111412
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MEDIAN,
        ST_BUILD,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic med_step;
        logic build_step;
        logic build_last;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic sched_ready;
        logic out_free;
    } t_status;

endpackage

// ===== src/wqrr_ctrl.sv =====
// Controller of the weighted quantum round-robin scheduler: accepts items and
// sequences the median search, the schedule build and the tick. Uses wqrr_pkg.
`timescale 1ns / 1ps
`include "weighted_quantum_round_robin_macros.svh"

module wqrr_ctrl #(
    parameter int NUM_TASKS = 7,
    parameter int IDX_W     = 3
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_func,
    input  wqrr_pkg::t_status   i_status,
    output logic                o_in_ready,
    output wqrr_pkg::t_cmd      o_cmd,
    output logic [IDX_W-1:0]    o_idx
);
    import wqrr_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TASKS - 1);

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic               w_accept;

    assign w_accept = i_in_valid && (r_state == ST_IDLE);
    assign o_idx    = r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_in_func == FUNC_TICK)) begin
                    n_state = i_status.sched_ready ? ST_EMIT : ST_MEDIAN;
                end
            end
            ST_MEDIAN: begin
                if (r_idx == LAST_IDX) begin
                    n_state = ST_BUILD;
                    n_idx   = '0;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_BUILD: begin
                if (r_idx == LAST_IDX) begin
                    n_state = ST_EMIT;
                    n_idx   = '0;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_idx   = '0;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid && (i_in_func == FUNC_LOAD);
            end
            ST_MEDIAN: begin
                o_cmd.med_step = 1'b1;
            end
            ST_BUILD: begin
                o_cmd.build_step = 1'b1;
                o_cmd.build_last = (r_idx == LAST_IDX);
            end
            ST_EMIT: begin
                o_cmd.emit = i_status.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    `WQRR_ASSERT_NEXT(a_tick_rebuilds, i_clk, i_rst_n, w_accept && (i_in_func == FUNC_TICK) && !i_status.sched_ready, r_state == ST_MEDIAN)
    `WQRR_ASSERT_IMP(a_emit_has_schedule, i_clk, i_rst_n, r_state == ST_EMIT, i_status.sched_ready)
    `WQRR_ASSERT_IMP(a_idx_parked, i_clk, i_rst_n, (r_state == ST_IDLE) || (r_state == ST_EMIT), r_idx == '0)

endmodule

// ===== src/wqrr_dp.sv =====
// Datapath of the weighted quantum round-robin scheduler: task stores, median
// rank unit, quantum multiplier, order list and the result register. Uses wqrr_pkg.
`timescale 1ns / 1ps
`include "weighted_quantum_round_robin_macros.svh"

module wqrr_dp #(
    parameter int NUM_TASKS    = 7,
    parameter int TOP_PRIORITY = 6,
    parameter int IDX_W        = 3,
    parameter int CNT_W        = 3
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  wqrr_pkg::t_cmd                      i_cmd,
    input  logic [IDX_W-1:0]                    i_idx,
    input  logic [wqrr_pkg::SLOT_W-1:0]         i_slot,
    input  logic [wqrr_pkg::BURST_W-1:0]        i_burst,
    input  logic [wqrr_pkg::PRIO_W-1:0]         i_prio,
    output wqrr_pkg::t_status                   o_status,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [wqrr_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    output logic                                o_m_tuser,
    output logic                                o_m_tlast
);
    import wqrr_pkg::*;

    localparam logic [CNT_W-1:0]  MED_RANK = CNT_W'(NUM_TASKS / 2);
    localparam logic [PRIO_W-1:0] TOP_P    = PRIO_W'(TOP_PRIORITY);
    localparam int                PROD_W   = BURST_W + COEF_W;

    logic [BURST_W-1:0]     r_burst [NUM_TASKS];
    logic [PRIO_W-1:0]      r_prio  [NUM_TASKS];
    logic [SLICE_W-1:0]     r_slice [NUM_TASKS];
    logic [BURST_W-1:0]     r_rem   [NUM_TASKS];
    logic [IDX_W-1:0]       r_order [NUM_TASKS];
    logic [BURST_W-1:0]     r_median;
    logic [CNT_W-1:0]       r_len;
    logic [IDX_W-1:0]       r_pos;
    logic [TURN_W-1:0]      r_turn;
    logic                   r_ready;
    logic                   r_out_valid;
    logic [OUT_DATA_W-1:0]  r_out_data;
    logic                   r_out_user;
    logic                   r_out_last;

    logic [NUM_TASKS-1:0]   w_less;
    logic [NUM_TASKS-1:0]   w_sched;
    logic [NUM_TASKS-1:0]   w_ahead;
    logic [CNT_W-1:0]       w_rank;
    logic [CNT_W-1:0]       w_cnt_sched;
    logic [IDX_W-1:0]       w_opos;
    logic [PROD_W-1:0]      w_prod;
    logic [SLICE_W-1:0]     w_new_slice;
    logic [IDX_W-1:0]       w_cur;
    logic [BURST_W-1:0]     w_rem;
    logic [SLICE_W-1:0]     w_sl;
    logic                   w_end;
    logic                   w_empty;
    logic [CNT_W-1:0]       w_pos_inc;
    logic                   w_slot_ok;

    // Stable rank of the candidate slot among all bursts, and its position in
    // the run order (higher priority first, lower slot first on a tie).
    always_comb begin
        for (int j = 0; j < NUM_TASKS; j++) begin
            w_less[j]  = (r_burst[j] < r_burst[i_idx]) ||
                         ((r_burst[j] == r_burst[i_idx]) && (IDX_W'(j) < i_idx));
            w_sched[j] = (r_prio[j] != '0) && (r_prio[j] <= TOP_P);
            w_ahead[j] = w_sched[j] &&
                         ((r_prio[j] > r_prio[i_idx]) ||
                          ((r_prio[j] == r_prio[i_idx]) && (IDX_W'(j) < i_idx)));
        end
    end

    assign w_rank      = CNT_W'($countones(w_less));
    assign w_cnt_sched = CNT_W'($countones(w_sched));
    assign w_opos      = IDX_W'($countones(w_ahead));
    assign w_prod      = PROD_W'(r_median) * PROD_W'(SLICE_COEF[r_prio[i_idx]]);
    assign w_new_slice = w_prod[COEF_SHIFT +: SLICE_W];

    assign w_cur     = r_order[r_pos];
    assign w_rem     = r_rem[w_cur];
    assign w_sl      = r_slice[w_cur];
    assign w_end     = ({1'b0, r_turn} >= {1'b0, w_sl});
    assign w_empty   = (r_len == '0);
    assign w_pos_inc = CNT_W'(r_pos) + 1'b1;
    assign w_slot_ok = (int'(i_slot) < NUM_TASKS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_TASKS; k++) begin
                r_burst[k] <= '0;
                r_prio[k]  <= '0;
                r_slice[k] <= '0;
                r_rem[k]   <= '0;
            end
            r_len       <= '0;
            r_pos       <= '0;
            r_turn      <= '0;
            r_ready     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.load) begin
                if (w_slot_ok) begin
                    r_burst[IDX_W'(i_slot)] <= i_burst;
                    r_prio[IDX_W'(i_slot)]  <= i_prio;
                    r_rem[IDX_W'(i_slot)]   <= i_burst;
                end
                r_ready <= 1'b0;
            end
            if (i_cmd.build_step) begin
                r_slice[i_idx] <= w_new_slice;
            end
            if (i_cmd.build_last) begin
                r_len   <= w_cnt_sched;
                r_pos   <= '0;
                r_turn  <= '0;
                r_ready <= 1'b1;
            end
            if (i_cmd.emit) begin
                if (!w_empty) begin
                    if (w_end) begin
                        if (w_rem == '0) begin
                            r_rem[w_cur] <= r_burst[w_cur];
                        end
                        r_turn <= '0;
                        r_pos  <= (w_pos_inc == r_len) ? '0 : w_pos_inc[IDX_W-1:0];
                    end else begin
                        if (w_rem != '0) begin
                            r_rem[w_cur] <= w_rem - 1'b1;
                        end
                        r_turn <= r_turn + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.med_step && (w_rank == MED_RANK)) begin
            r_median <= r_burst[i_idx];
        end
        if (i_cmd.build_step && w_sched[i_idx]) begin
            r_order[w_opos] <= i_idx;
        end
        if (i_cmd.emit) begin
            r_out_user <= w_empty;
            r_out_last <= !w_empty && w_end;
            r_out_data <= w_empty ? '0
                        : OUT_DATA_W'({w_sl, w_rem, r_turn, SLOT_W'(w_cur)});
        end
    end

    assign o_status.sched_ready = r_ready;
    assign o_status.out_free    = !r_out_valid || i_m_tready;
    assign o_m_tvalid           = r_out_valid;
    assign o_m_tdata            = r_out_data;
    assign o_m_tuser            = r_out_user;
    assign o_m_tlast            = r_out_last;

    `WQRR_ASSERT_IMP(a_pos_in_range, i_clk, i_rst_n, r_ready && (r_len != '0), CNT_W'(r_pos) < r_len)
    `WQRR_ASSERT_IMP(a_turn_within_slice, i_clk, i_rst_n, r_ready && (r_len != '0), r_turn <= w_sl)
    `WQRR_ASSERT_NEXT(a_empty_is_idle, i_clk, i_rst_n, i_cmd.emit && (r_len == '0), o_m_tuser && !o_m_tlast)

endmodule

// ===== src/weighted_quantum_round_robin.sv =====
// Top level of the weighted quantum round-robin scheduler.
// Instantiates wqrr_ctrl and wqrr_dp; uses wqrr_pkg.
`timescale 1ns / 1ps

// Usage:
// The input stream carries two kinds of item, chosen by i_s_tuser. A load item
// (tuser 0) writes a slot's burst time and priority and invalidates the
// schedule; it gives no result and the block stays ready. A tick item (tuser 1)
// gives exactly one result item: the slot running this tick, its turn count
// and remaining time before the update, its quantum, tlast when the tick ends
// the turn, and tuser high with zero data when no task is schedulable.
// A tick on a valid schedule is accepted in idle and goes to the emit state,
// which registers the result once the output register is free and goes idle.
// The first tick after any load also rebuilds the schedule: a median search
// over all slots (one slot ranked per cycle against all bursts), then a build
// pass computing one quantum and one order entry per cycle on the shared
// multiplier, before the tick goes to the emit state.
// Reset clears all task slots and the schedule; the first tick rebuilds it.
// When the receiver stalls, the result holds in the output register; a tick
// then waits until the register is free, while no further item is accepted.
module weighted_quantum_round_robin #(
    parameter int NUM_TASKS    = 7,
    parameter int TOP_PRIORITY = 6
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // slot[2:0], burst_time[10:3], task_priority[13:11], zero pad[15:14]
    input  logic [wqrr_pkg::IN_DATA_W-1:0]      i_s_tdata,
    // func[0]: 0 load, 1 tick
    input  logic                                i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // running_slot[2:0], executed_before[11:3], remaining_before[19:12],
    // slice_length[28:20], zero pad[31:29]
    output logic [wqrr_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    // idle[0]
    output logic                                o_m_tuser,
    // turn_end
    output logic                                o_m_tlast
);
    import wqrr_pkg::*;

    localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int CNT_W = $clog2(NUM_TASKS + 1);

    t_cmd               w_cmd;
    t_status            w_status;
    logic [IDX_W-1:0]   w_idx;

    wqrr_ctrl #(
        .NUM_TASKS (NUM_TASKS),
        .IDX_W     (IDX_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_in_func  (i_s_tuser),
        .i_status   (w_status),
        .o_in_ready (o_s_tready),
        .o_cmd      (w_cmd),
        .o_idx      (w_idx)
    );

    wqrr_dp #(
        .NUM_TASKS    (NUM_TASKS),
        .TOP_PRIORITY (TOP_PRIORITY),
        .IDX_W        (IDX_W),
        .CNT_W        (CNT_W)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_idx      (w_idx),
        .i_slot     (i_s_tdata[SLOT_W-1:0]),
        .i_burst    (i_s_tdata[SLOT_W +: BURST_W]),
        .i_prio     (i_s_tdata[SLOT_W + BURST_W +: PRIO_W]),
        .o_status   (w_status),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

// ===== verif/wqrr_schedule_checker.sv =====
// Checker for the weighted quantum round-robin scheduler: watches both streams,
// predicts each tick result from its own copy of the schedule and compares fields.
// Depends on wqrr_pkg for widths and item kinds.
`timescale 1ns / 1ps

module wqrr_schedule_checker
    import wqrr_pkg::*;
#(
    parameter int NUM_TASKS    = 7,
    parameter int TOP_PRIORITY = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    // slot[2:0], burst_time[10:3], task_priority[13:11], zero pad[15:14]
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // func[0]
    input  logic                  i_s_tuser,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    // running_slot[2:0], executed_before[11:3], remaining_before[19:12],
    // slice_length[28:20], zero pad[31:29]
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    // idle[0]
    input  logic                  i_m_tuser,
    input  logic                  i_m_tlast,
    output int                    o_pending,
    output int                    o_mismatches
);

    typedef struct {
        logic               idle;
        logic [SLOT_W-1:0]  running_slot;
        logic [TURN_W-1:0]  executed_before;
        logic [BURST_W-1:0] remaining_before;
        logic [SLICE_W-1:0] slice_length;
        logic               turn_end;
    } t_tick_report;

    t_tick_report       due_reports[$];
    logic [BURST_W-1:0] burst_mem  [NUM_TASKS];
    logic [PRIO_W-1:0]  prio_mem   [NUM_TASKS];
    logic [SLICE_W-1:0] slice_mem  [NUM_TASKS];
    logic [BURST_W-1:0] remain_mem [NUM_TASKS];
    int                 run_order  [NUM_TASKS];
    int                 order_len;
    int                 order_pos;
    logic [TURN_W-1:0]  turn_count;
    logic               sched_valid;
    int                 mismatch_count;

    assign o_mismatches = mismatch_count;

    initial begin
        for (int i = 0; i < NUM_TASKS; i++) begin
            burst_mem[i]  = '0;
            prio_mem[i]   = '0;
            slice_mem[i]  = '0;
            remain_mem[i] = '0;
            run_order[i]  = 0;
        end
        order_len      = 0;
        order_pos      = 0;
        turn_count     = '0;
        sched_valid    = 1'b0;
        mismatch_count = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // Four-state compare, so an unknown bit on the output never passes.
    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    function automatic logic [BURST_W-1:0] median_burst();
        logic [BURST_W-1:0] sorted [NUM_TASKS];
        logic [BURST_W-1:0] held;
        int                 j;
        sorted = burst_mem;
        for (int i = 1; i < NUM_TASKS; i++) begin
            held = sorted[i];
            j = i;
            while (j > 0 && sorted[j-1] > held) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = held;
        end
        return sorted[NUM_TASKS/2];
    endfunction

    // Quanta are exact integer scaling of the median; the order list runs
    // from the top priority down, equal priorities by ascending slot.
    task automatic rebuild_schedule();
        int med;
        med = int'(median_burst());
        for (int i = 0; i < NUM_TASKS; i++)
            slice_mem[i] = SLICE_W'((med * (10 + int'(prio_mem[i]))) / 10);
        order_len = 0;
        for (int p = TOP_PRIORITY; p > 0; p--) begin
            for (int i = 0; i < NUM_TASKS; i++) begin
                if (int'(prio_mem[i]) == p) begin
                    run_order[order_len] = i;
                    order_len++;
                end
            end
        end
        order_pos   = 0;
        turn_count  = '0;
        sched_valid = 1'b1;
    endtask

    task automatic apply_item(input logic func, input logic [IN_DATA_W-1:0] data);
        logic [SLOT_W-1:0]  slot;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
        logic [BURST_W-1:0] rem;
        t_tick_report       rep;
        int                 s;
        slot  = data[2:0];
        burst = data[10:3];
        prio  = data[13:11];
        if (func == FUNC_LOAD) begin
            // A load to a slot past the table still invalidates the schedule.
            if (slot < NUM_TASKS) begin
                burst_mem[slot]  = burst;
                prio_mem[slot]   = prio;
                remain_mem[slot] = burst;
            end
            sched_valid = 1'b0;
            return;
        end
        if (!sched_valid)
            rebuild_schedule();
        rep = '{default: '0};
        if (order_len == 0) begin
            rep.idle = 1'b1;
            due_reports = {due_reports, rep};
            return;
        end
        if (order_pos >= order_len)
            order_pos = 0;
        s   = run_order[order_pos];
        rem = remain_mem[s];
        rep.running_slot     = SLOT_W'(s);
        rep.executed_before  = turn_count;
        rep.remaining_before = rem;
        rep.slice_length     = slice_mem[s];
        rep.turn_end         = (turn_count >= slice_mem[s]);
        due_reports = {due_reports, rep};
        if (rep.turn_end) begin
            if (rem == 0)
                remain_mem[s] = burst_mem[s];
            turn_count = '0;
            order_pos++;
            if (order_pos >= order_len)
                order_pos = 0;
        end else begin
            if (rem > 0)
                remain_mem[s] = rem - 1'b1;
            turn_count = turn_count + 1'b1;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_tick_report want;
        if (i_rst_n) begin
            if (i_m_tvalid && i_m_tready) begin
                if (due_reports.size() == 0) begin
                    report_mismatch("result item with no tick waiting for it");
                end else begin
                    want = due_reports.pop_front();
                    check_field("idle", 32'(i_m_tuser), 32'(want.idle));
                    check_field("running_slot", 32'(i_m_tdata[2:0]),
                                32'(want.running_slot));
                    check_field("executed_before", 32'(i_m_tdata[11:3]),
                                32'(want.executed_before));
                    check_field("remaining_before", 32'(i_m_tdata[19:12]),
                                32'(want.remaining_before));
                    check_field("slice_length", 32'(i_m_tdata[28:20]),
                                32'(want.slice_length));
                    check_field("turn_end", 32'(i_m_tlast), 32'(want.turn_end));
                    check_field("tdata pad", 32'(i_m_tdata[31:29]), 32'd0);
                end
            end
            if (i_s_tvalid && i_s_tready)
                apply_item(i_s_tuser, i_s_tdata);
        end
        o_pending <= due_reports.size();
    end

endmodule

// ===== verif/weighted_quantum_round_robin_tb.sv =====
// Testbench top for the weighted quantum round-robin scheduler: clock, reset,
// load and tick stimulus with random gaps and stalls, and the final verdict.
// Depends on wqrr_pkg, weighted_quantum_round_robin and wqrr_schedule_checker.
`timescale 1ns / 1ps

module weighted_quantum_round_robin_tb;
    import wqrr_pkg::*;

    localparam int NUM_TASKS    = 7;
    localparam int TOP_PRIORITY = 6;
    localparam int RANDOM_ITEMS = 650;
    localparam int CYCLE_LIMIT  = 400000;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata  = '0;
    logic                  i_s_tuser  = 1'b0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  o_m_tuser;
    logic                  o_m_tlast;

    bit steady_flow = 1'b0;
    int pending_ticks;
    int mismatches;
    int random_items = 0;
    bit pressure_done = 1'b0;

    always #5 i_clk = ~i_clk;

    // Receiver stalls at random except during the steady stretch.
    always @(posedge i_clk)
        i_m_tready <= steady_flow || ($urandom_range(99) >= 34);

    weighted_quantum_round_robin #(
        .NUM_TASKS    (NUM_TASKS),
        .TOP_PRIORITY (TOP_PRIORITY)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    wqrr_schedule_checker #(
        .NUM_TASKS    (NUM_TASKS),
        .TOP_PRIORITY (TOP_PRIORITY)
    ) schedule_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .i_m_tlast    (o_m_tlast),
        .o_pending    (pending_ticks),
        .o_mismatches (mismatches)
    );

    // Valid stays high from one item to the next unless a gap is drawn.
    task automatic send_item(input logic func, input logic [SLOT_W-1:0] slot,
                             input logic [BURST_W-1:0] burst,
                             input logic [PRIO_W-1:0] prio);
        if (!steady_flow) begin
            while ($urandom_range(99) < 34) begin
                i_s_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= func;
        i_s_tdata  <= {2'b00, prio, burst, slot};
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
    endtask

    task automatic send_tick();
        send_item(FUNC_TICK, SLOT_W'($urandom), BURST_W'($urandom), PRIO_W'($urandom));
    endtask

    // The pending count is registered, so look at it only from the edge after the last item.
    task automatic settle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_ticks != 0)
            @(posedge i_clk);
    endtask

    // Mostly short bursts so that turns end and remaining times run out.
    function automatic logic [BURST_W-1:0] pick_burst();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return BURST_W'($urandom_range(0, 12));
        else if (r < 85)
            return BURST_W'($urandom_range(0, 255));
        else if (r < 93)
            return '0;
        else
            return '1;
    endfunction

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int n_loads;
        int n_ticks;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty schedule right after reset, then a load past the last slot.
        send_tick();
        send_item(FUNC_LOAD, 3'd7, 8'd255, 3'd6);
        send_tick();
        // Median of zero: every quantum is zero, unscheduled priorities 0 and 7.
        send_item(FUNC_LOAD, 3'd0, 8'd255, 3'd6);
        send_item(FUNC_LOAD, 3'd1, 8'd0, 3'd1);
        send_item(FUNC_LOAD, 3'd6, 8'd1, 3'd7);
        send_item(FUNC_LOAD, 3'd2, 8'd2, 3'd0);
        repeat (3) send_tick();
        // Median of two: short quanta, and a task that runs out and reloads.
        send_item(FUNC_LOAD, 3'd3, 8'd2, 3'd3);
        send_item(FUNC_LOAD, 3'd4, 8'd2, 3'd4);
        send_item(FUNC_LOAD, 3'd5, 8'd3, 3'd5);
        repeat (12) send_tick();

        while (random_items < RANDOM_ITEMS) begin
            if (!pressure_done && random_items >= 300) begin
                settle();
                pressure_done = 1'b1;
            end
            steady_flow <= (random_items >= 150 && random_items < 260);
            // A full table load is the usual case; a few stray loads act as noise.
            if ($urandom_range(2) != 0) begin
                for (int i = 0; i < NUM_TASKS; i++) begin
                    send_item(FUNC_LOAD, SLOT_W'(i), pick_burst(),
                              PRIO_W'($urandom_range(0, 7)));
                    random_items++;
                end
            end else begin
                n_loads = $urandom_range(0, 3);
                for (int i = 0; i < n_loads; i++) begin
                    send_item(FUNC_LOAD, SLOT_W'($urandom_range(0, 7)), pick_burst(),
                              PRIO_W'($urandom_range(0, 7)));
                    random_items++;
                end
            end
            n_ticks = $urandom_range(1, 50);
            for (int i = 0; i < n_ticks; i++) begin
                send_tick();
                random_items++;
            end
        end

        settle();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
